>>> sv/kmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmh_pkg - shared types and constants for the key matrix to HID report core
// Beat payloads, controller command struct and the fixed 5x14 keymap ROM.
// ----------------------------------------------------------------------------
package kmh_pkg;

    localparam int MAP_ROWS  = 5;
    localparam int MAP_COLS  = 14;
    localparam int OUT_SLOTS = 6;
    localparam int ROW_W     = $clog2(MAP_ROWS);
    localparam int COL_W     = $clog2(MAP_COLS);

    // Fn keys sit at row 4, columns 1 and 12
    localparam logic [MAP_COLS-1:0] FN_MASK = MAP_COLS'((1 << 1) | (1 << 12));

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_KEY,
        KIND_MOD
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] normal;   // usage, or modifier bit index for KIND_MOD
        logic [7:0] layer;    // Fn-layer usage
    } t_map_entry;

    typedef struct packed {
        logic [MAP_COLS-1:0] row0_bits;
        logic [MAP_COLS-1:0] row1_bits;
        logic [MAP_COLS-1:0] row2_bits;
        logic [MAP_COLS-1:0] row3_bits;
        logic [MAP_COLS-1:0] row4_bits;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] slot0_code;
        logic [7:0] slot1_code;
        logic [7:0] slot2_code;
        logic [7:0] slot3_code;
        logic [7:0] slot4_code;
        logic [7:0] slot5_code;
    } t_out_beat;

    typedef struct packed {
        logic             load;     // capture scan, form change mask
        logic             step;     // process one matrix position
        logic             publish;  // copy report into output register
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_dp_cmd;

    function automatic t_map_entry mk_lay(input logic [7:0] n, input logic [7:0] f);
        mk_lay = '{KIND_KEY, n, f};
    endfunction

    function automatic t_map_entry mk_key(input logic [7:0] c);
        mk_key = '{KIND_KEY, c, c};
    endfunction

    function automatic t_map_entry mk_mod(input logic [2:0] b);
        mk_mod = '{KIND_MOD, {5'd0, b}, 8'h00};
    endfunction

    function automatic t_map_entry mk_nop();
        mk_nop = '{KIND_NONE, 8'h00, 8'h00};
    endfunction

    localparam t_map_entry KEYMAP [MAP_ROWS][MAP_COLS] = '{
        '{mk_lay(8'h35, 8'h29), mk_lay(8'h1E, 8'h3A), mk_lay(8'h1F, 8'h3B),
          mk_lay(8'h20, 8'h3C), mk_lay(8'h21, 8'h3D), mk_lay(8'h22, 8'h3E),
          mk_lay(8'h23, 8'h3F), mk_lay(8'h24, 8'h40), mk_lay(8'h25, 8'h41),
          mk_lay(8'h26, 8'h42), mk_lay(8'h27, 8'h43), mk_lay(8'h2D, 8'h44),
          mk_lay(8'h2E, 8'h45), mk_lay(8'h2A, 8'h4C)},
        '{mk_key(8'h2B), mk_key(8'h14), mk_key(8'h1A), mk_key(8'h08),
          mk_key(8'h15), mk_key(8'h17), mk_key(8'h1C), mk_key(8'h18),
          mk_lay(8'h0C, 8'h4D), mk_lay(8'h12, 8'h4E), mk_lay(8'h13, 8'h52),
          mk_lay(8'h2F, 8'h4B), mk_lay(8'h30, 8'h4A), mk_key(8'h31)},
        '{mk_key(8'h29), mk_key(8'h04), mk_key(8'h16), mk_key(8'h07),
          mk_key(8'h09), mk_key(8'h0A), mk_key(8'h0B), mk_key(8'h0D),
          mk_key(8'h0E), mk_lay(8'h0F, 8'h50), mk_lay(8'h33, 8'h51),
          mk_lay(8'h34, 8'h4F), mk_nop(), mk_key(8'h28)},
        '{mk_mod(3'd1), mk_lay(8'h1D, 8'h7F), mk_lay(8'h1B, 8'h81),
          mk_lay(8'h06, 8'h80), mk_key(8'h19), mk_key(8'h05), mk_key(8'h11),
          mk_key(8'h10), mk_key(8'h36), mk_key(8'h37), mk_key(8'h38),
          mk_nop(), mk_nop(), mk_mod(3'd5)},
        '{mk_mod(3'd0), mk_nop(), mk_mod(3'd3), mk_mod(3'd2),
          mk_lay(8'h2C, 8'h4C), mk_nop(), mk_lay(8'h2C, 8'h4C), mk_nop(),
          mk_nop(), mk_mod(3'd6), mk_mod(3'd7), mk_key(8'h65), mk_nop(),
          mk_mod(3'd4)}
    };

endpackage

>>> sv/kmh_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmh_dp - report datapath
// Holds the scan, change mask, slots and modifiers; applies one matrix
// position per step command and fills the output register on publish.
// ----------------------------------------------------------------------------
module kmh_dp #(
    parameter int REPORT_SLOT_COUNT = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kmh_pkg::t_dp_cmd  i_cmd,
    input  kmh_pkg::t_in_beat i_in_data,
    output kmh_pkg::t_out_beat o_out_data
);
    import kmh_pkg::*;

    logic [MAP_COLS-1:0] r_scan  [MAP_ROWS];
    logic [MAP_COLS-1:0] r_delta [MAP_ROWS];
    logic                r_fn;
    logic [7:0]          r_slots [REPORT_SLOT_COUNT];
    logic [7:0]          n_slots [REPORT_SLOT_COUNT];
    logic [7:0]          r_mods;
    logic [7:0]          n_mods;
    t_out_beat           r_out;

    logic [MAP_COLS-1:0] in_rows [MAP_ROWS];
    logic [7:0]          out_slots [OUT_SLOTS];
    t_map_entry          entry;
    logic                changed;
    logic                pressed;
    logic [7:0]          code;
    logic                hit;
    logic                seen_free;
    logic [REPORT_SLOT_COUNT-1:0] free_sel;

    assign in_rows[0] = i_in_data.row0_bits;
    assign in_rows[1] = i_in_data.row1_bits;
    assign in_rows[2] = i_in_data.row2_bits;
    assign in_rows[3] = i_in_data.row3_bits;
    assign in_rows[4] = i_in_data.row4_bits;

    assign entry   = KEYMAP[i_cmd.row][i_cmd.col];
    assign changed = r_delta[i_cmd.row][i_cmd.col];
    assign pressed = r_scan[i_cmd.row][i_cmd.col];
    assign code    = r_fn ? entry.layer : entry.normal;

    always_comb begin
        n_slots   = r_slots;
        n_mods    = r_mods;
        hit       = 1'b0;
        seen_free = 1'b0;
        free_sel  = '0;
        for (int i = 0; i < REPORT_SLOT_COUNT; i++) begin
            if (r_slots[i] == code) begin
                hit = 1'b1;
            end
            // lowest empty slot only
            if (!seen_free && r_slots[i] == 8'h00) begin
                free_sel[i] = 1'b1;
                seen_free   = 1'b1;
            end
        end
        if (i_cmd.step && changed) begin
            case (entry.kind)
                KIND_MOD: begin
                    n_mods[entry.normal[2:0]] = pressed;
                end
                KIND_KEY: begin
                    if (pressed) begin
                        if (!hit) begin
                            for (int i = 0; i < REPORT_SLOT_COUNT; i++) begin
                                if (free_sel[i]) begin
                                    n_slots[i] = code;
                                end
                            end
                        end
                    end else begin
                        for (int i = 0; i < REPORT_SLOT_COUNT; i++) begin
                            if (r_slots[i] == entry.normal || r_slots[i] == entry.layer) begin
                                n_slots[i] = 8'h00;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < OUT_SLOTS; g++) begin : g_out
        if (g < REPORT_SLOT_COUNT) begin : g_live
            assign out_slots[g] = r_slots[g];
        end else begin : g_zero
            assign out_slots[g] = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAP_ROWS; r++) begin
                r_scan[r] <= '0;
            end
            for (int i = 0; i < REPORT_SLOT_COUNT; i++) begin
                r_slots[i] <= 8'h00;
            end
            r_mods <= 8'h00;
        end else begin
            if (i_cmd.load) begin
                for (int r = 0; r < MAP_ROWS; r++) begin
                    r_scan[r] <= in_rows[r];
                end
            end
            r_slots <= n_slots;
            r_mods  <= n_mods;
        end
    end

    // payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int r = 0; r < MAP_ROWS; r++) begin
                r_delta[r] <= in_rows[r] ^ r_scan[r];
            end
            r_fn <= |(i_in_data.row4_bits & FN_MASK);
        end
        if (i_cmd.publish) begin
            r_out.modifier_bits <= r_mods;
            r_out.slot0_code    <= out_slots[0];
            r_out.slot1_code    <= out_slots[1];
            r_out.slot2_code    <= out_slots[2];
            r_out.slot3_code    <= out_slots[3];
            r_out.slot4_code    <= out_slots[4];
            r_out.slot5_code    <= out_slots[5];
        end
    end

    assign o_out_data = r_out;

endmodule

>>> sv/kmh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmh_ctrl - scan walk controller
// Takes an input beat, walks the active matrix positions row by row and
// hands the finished report to the output register.
// ----------------------------------------------------------------------------
module kmh_ctrl #(
    parameter int MATRIX_ROWS = 5,
    parameter int MATRIX_COLS = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output kmh_pkg::t_dp_cmd o_cmd
);
    import kmh_pkg::*;

    localparam int ROWS_EFF = (MATRIX_ROWS < MAP_ROWS) ? MATRIX_ROWS : MAP_ROWS;
    localparam int COLS_EFF = (MATRIX_COLS < MAP_COLS) ? MATRIX_COLS : MAP_COLS;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS_EFF - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS_EFF - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_out_valid;
    logic             publish;

    // output register free, or being drained this cycle
    assign publish = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.step    = (r_state == S_WALK);
    assign o_cmd.publish = publish;
    assign o_cmd.row     = r_row;
    assign o_cmd.col     = r_col;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_row   <= '0;
                        r_col   <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_col == LAST_COL) begin
                        r_col <= '0;
                        if (r_row == LAST_ROW) begin
                            r_state <= S_DONE;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_DONE: begin
                    if (publish) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/key_matrix_to_hid_report_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_to_hid_report_core - matrix scan to 6-key boot report
// Takes a beat in idle, walks min(MATRIX_ROWS,5) x min(MATRIX_COLS,14) positions
// one position per cycle, then publishes once the output register is free.
// No new beat is taken until the previous report has been published.
// Reset (synchronous, active low) clears held scan, slots, modifiers and valid.
// ----------------------------------------------------------------------------
module key_matrix_to_hid_report_core #(
    parameter int MATRIX_ROWS       = 5,
    parameter int MATRIX_COLS       = 14,
    parameter int REPORT_SLOT_COUNT = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  kmh_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output kmh_pkg::t_out_beat o_out_data
);
    import kmh_pkg::*;

    t_dp_cmd cmd;

    kmh_ctrl #(
        .MATRIX_ROWS (MATRIX_ROWS),
        .MATRIX_COLS (MATRIX_COLS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    kmh_dp #(
        .REPORT_SLOT_COUNT (REPORT_SLOT_COUNT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for key_matrix_to_hid_report_core
// Drives whole matrix scans with random gaps, tracks held keys, Fn layer,
// modifiers and the six report slots in a local model, and checks every
// report beat against it field by field. Covers directed corner scans,
// realistic typing, raw noise, a gap-free stretch and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
    import kmh_pkg::*;

    localparam int CYCLE_NS    = 12;
    localparam int DRAIN_WAIT  = 80;
    localparam int LIMIT_TICKS = 600000;

    localparam logic [13:0] FN_KEYS = 14'h1002;

    // per position: usage code (or modifier bit index) and Fn-layer usage
    localparam logic [7:0] NORMAL_CODE [5][14] = '{
        '{8'h35, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
          8'h27, 8'h2D, 8'h2E, 8'h2A},
        '{8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12,
          8'h13, 8'h2F, 8'h30, 8'h31},
        '{8'h29, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F,
          8'h33, 8'h34, 8'h00, 8'h28},
        '{8'h01, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37,
          8'h38, 8'h00, 8'h00, 8'h05},
        '{8'h00, 8'h00, 8'h03, 8'h02, 8'h2C, 8'h00, 8'h2C, 8'h00, 8'h00, 8'h06,
          8'h07, 8'h65, 8'h00, 8'h04}
    };
    localparam logic [7:0] FN_CODE [5][14] = '{
        '{8'h29, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42,
          8'h43, 8'h44, 8'h45, 8'h4C},
        '{8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h4D, 8'h4E,
          8'h52, 8'h4B, 8'h4A, 8'h31},
        '{8'h29, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h50,
          8'h51, 8'h4F, 8'h00, 8'h28},
        '{8'h00, 8'h7F, 8'h81, 8'h80, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37,
          8'h38, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h4C, 8'h00, 8'h4C, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h65, 8'h00, 8'h00}
    };
    localparam logic [13:0] MOD_POS [5] = '{14'h0000, 14'h0000, 14'h0000,
                                            14'h2001, 14'h260D};
    localparam logic [13:0] NOP_POS [5] = '{14'h0000, 14'h0000, 14'h1000,
                                            14'h1800, 14'h11A2};

    localparam string FIELD_NAME [7] = '{"modifiers", "slot0", "slot1", "slot2",
                                         "slot3", "slot4", "slot5"};

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    // local copy of the block's state
    logic [13:0] held_scan [5];
    logic [7:0]  slot_code [6];
    logic [7:0]  modifier_state;

    t_out_beat pending_reports [$];
    int        mismatches      = 0;
    bit        no_idle         = 1'b0;
    int        hold_off_cycles = 0;

    key_matrix_to_hid_report_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #(CYCLE_NS / 2.0) i_clk = ~i_clk;
    end

    initial begin
        #(CYCLE_NS * LIMIT_TICKS);
        $display("Some tests failed");
        $finish;
    end

    function automatic t_kind kind_at(input int r, input int c);
        if (MOD_POS[r][c])
            return KIND_MOD;
        if (NOP_POS[r][c])
            return KIND_NONE;
        return KIND_KEY;
    endfunction

    // walk changed positions row-major and return the resulting report
    function automatic t_out_beat update_report(input t_in_beat scan);
        logic [13:0] rows [5];
        logic [13:0] delta;
        logic [7:0]  code;
        logic        fn_held;
        logic        pressed;
        bit          done;
        rows[0] = scan.row0_bits;
        rows[1] = scan.row1_bits;
        rows[2] = scan.row2_bits;
        rows[3] = scan.row3_bits;
        rows[4] = scan.row4_bits;
        fn_held = |(rows[4] & FN_KEYS);
        for (int r = 0; r < 5; r++) begin
            delta = rows[r] ^ held_scan[r];
            for (int c = 0; c < 14; c++) begin
                if (!delta[c])
                    continue;
                pressed = rows[r][c];
                case (kind_at(r, c))
                    KIND_MOD: begin
                        modifier_state[NORMAL_CODE[r][c][2:0]] = pressed;
                    end
                    KIND_KEY: begin
                        if (pressed) begin
                            code = fn_held ? FN_CODE[r][c] : NORMAL_CODE[r][c];
                            done = 1'b0;
                            foreach (slot_code[i])
                                if (slot_code[i] == code)
                                    done = 1'b1;
                            foreach (slot_code[i])
                                if (!done && slot_code[i] == 8'h00) begin
                                    slot_code[i] = code;
                                    done = 1'b1;
                                end
                        end else begin
                            foreach (slot_code[i])
                                if (slot_code[i] == NORMAL_CODE[r][c] ||
                                    slot_code[i] == FN_CODE[r][c])
                                    slot_code[i] = 8'h00;
                        end
                    end
                    default: ;
                endcase
            end
        end
        held_scan = rows;
        return '{modifier_state, slot_code[0], slot_code[1], slot_code[2],
                 slot_code[3], slot_code[4], slot_code[5]};
    endfunction

    function automatic t_in_beat scan_of(input logic [13:0] r0, input logic [13:0] r1,
                                         input logic [13:0] r2, input logic [13:0] r3,
                                         input logic [13:0] r4);
        return '{r0, r1, r2, r3, r4};
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    // one scan beat; valid is left high so back-to-back beats need no dip
    task automatic send_scan(input t_in_beat scan);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= scan;
        do @(posedge i_clk); while (!o_in_ready);
        pending_reports.push_back(update_report(scan));
    endtask

    // report sink and checker
    initial begin : report_checker
        t_out_beat  want;
        logic [7:0] want_f [7];
        logic [7:0] got_f [7];
        int         stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_reports.size() == 0) begin
                note_mismatch($sformatf("report beat %h with none pending", o_out_data));
            end else begin
                want   = pending_reports.pop_front();
                want_f = '{want.modifier_bits, want.slot0_code, want.slot1_code,
                           want.slot2_code, want.slot3_code, want.slot4_code,
                           want.slot5_code};
                got_f  = '{o_out_data.modifier_bits, o_out_data.slot0_code,
                           o_out_data.slot1_code, o_out_data.slot2_code,
                           o_out_data.slot3_code, o_out_data.slot4_code,
                           o_out_data.slot5_code};
                for (int i = 0; i < 7; i++)
                    if (got_f[i] !== want_f[i])
                        note_mismatch($sformatf("%s: expected %h, got %h",
                                                FIELD_NAME[i], want_f[i], got_f[i]));
            end
        end
    end

    task automatic test_directed();
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000));
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0000, 14'h0001, 14'h0000));
        send_scan(scan_of(14'h0000, 14'h0002, 14'h0000, 14'h0001, 14'h0000));
        send_scan(scan_of(14'h0000, 14'h0002, 14'h0000, 14'h0000, 14'h0000));
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000));
        // everything down with Fn: slots fill, rest dropped, all modifiers set
        send_scan(scan_of(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF));
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000));
        // both space keys share a code: second press skipped, one release clears it
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0050));
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0040));
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0042));
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0052));
        // other Fn column; layer code released after Fn lets go
        send_scan(scan_of(14'h0002, 14'h0000, 14'h0000, 14'h0000, 14'h1000));
        send_scan(scan_of(14'h0002, 14'h0000, 14'h0000, 14'h0000, 14'h0000));
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000));
        // Fn code of one key equals normal code of another
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0001, 14'h0000, 14'h0000));
        send_scan(scan_of(14'h0001, 14'h0000, 14'h0001, 14'h0000, 14'h0002));
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0001, 14'h0000, 14'h0000));
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0000, 14'h2001, 14'h260D));
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000));
        send_scan(scan_of(14'h0000, 14'h0000, 14'h1000, 14'h1800, 14'h11A2));
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0000, 14'h000E, 14'h0002));
        send_scan(scan_of(14'h2AAA, 14'h2AAA, 14'h2AAA, 14'h2AAA, 14'h2AAA));
        send_scan(scan_of(14'h1555, 14'h1555, 14'h1555, 14'h1555, 14'h1555));
        send_scan(scan_of(14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000));
    endtask

    // few keys change per scan, as when someone types; Fn toggled now and then
    task automatic test_typing(input int count);
        logic [13:0] rows [5];
        int          held_total;
        rows = '{default: '0};
        repeat (count) begin
            held_total = 0;
            foreach (rows[r])
                held_total += $countones(rows[r]);
            if (held_total > 9)
                rows[$urandom_range(0, 4)] = '0;
            repeat ($urandom_range(0, 3))
                rows[$urandom_range(0, 4)][$urandom_range(0, 13)] ^= 1'b1;
            if ($urandom_range(0, 5) == 0)
                rows[4] ^= ($urandom_range(0, 1) != 0) ? 14'h0002 : 14'h1000;
            send_scan(scan_of(rows[0], rows[1], rows[2], rows[3], rows[4]));
        end
    endtask

    task automatic test_noise(input int count);
        repeat (count)
            send_scan(scan_of(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                              14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                              14'($urandom_range(0, 16383))));
    endtask

    task automatic test_steady_stream();
        no_idle = 1'b1;
        test_typing(100);
        no_idle = 1'b0;
    endtask

    // sink stops for a long while; input must back up and stall
    task automatic test_output_stall();
        hold_off_cycles = 600;
        test_typing(10);
    endtask

    initial begin : stimulus
        held_scan      = '{default: '0};
        slot_code      = '{default: '0};
        modifier_state = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_typing(600);
        test_noise(250);
        test_steady_stream();
        test_output_stall();
        test_typing(120);
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
